/* design/mprqs_pkg.sv */
// ----------------------------------------------------------------------------
// mprqs_pkg: shared types and codes
// Action, status and policy codes and the sequencer state type.
// ----------------------------------------------------------------------------
package mprqs_pkg;

  localparam logic [2:0] ACT_ADMIT    = 3'd0;
  localparam logic [2:0] ACT_BLOCK    = 3'd1;
  localparam logic [2:0] ACT_FINISH   = 3'd2;
  localparam logic [2:0] ACT_EXPIRE   = 3'd3;
  localparam logic [2:0] ACT_UNBLOCK  = 3'd4;
  localparam logic [2:0] ACT_KILL     = 3'd5;
  localparam logic [2:0] ACT_DISPATCH = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [1:0] ST_IDLE      = 2'd3;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_RR   = 2'd2;
  localparam logic [1:0] POL_PRIO = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,      // read ready entry, compare keys
    S_SCAN_WAIT,
    S_TAKE,      // read picked ready entry
    S_TAKE_WAIT,
    S_RSHIFT,    // ready compaction, one entry per read/write
    S_RSHIFT_WR,
    S_BREAD,     // read blocked entry for unblock
    S_BREAD_WAIT,
    S_BSHIFT,
    S_BSHIFT_WR,
    S_DONE
  } state_t;

endpackage

/* design/multi_policy_ready_queue_scheduler.sv */
// ----------------------------------------------------------------------------
// multi_policy_ready_queue_scheduler
// Ready queue, blocked FIFO and running slot under a selectable policy.
// ----------------------------------------------------------------------------
// Usage: drive action and its fields with start high while busy is low; the
// event is taken at that edge and busy rises. When the event is done, done
// pulses for one cycle with running_valid/id/key, the counts and status.
// The receiver cannot stall; results must be taken on the done cycle.
// policy is written through cfg_data/cfg_valid/cfg_ready while no event runs.
// Simple events step from DECODE to DONE; the next start is taken once the
// block is back in IDLE.
// Dispatch scans the ready queue with one shared key comparator over the
// single memory read port, one read and one compare per entry, then compacts
// the queue moving one entry per read/write pair before done.
// Unblock/kill compact the blocked FIFO the same way.
// One event is in flight at a time; busy covers it all.
// Reset clears counts, running slot and policy; queue storage keeps its
// contents and is read only below the fill counts, so no clearing pass.
// ----------------------------------------------------------------------------
module multi_policy_ready_queue_scheduler #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [15:0] process_id,
  input  logic [7:0]  sched_key,
  input  logic [5:0]  blocked_index,
  input  logic [1:0]  cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  output logic        done,
  output logic        running_valid,
  output logic [15:0] running_id,
  output logic [7:0]  running_key,
  output logic [6:0]  ready_count,
  output logic [6:0]  blocked_count,
  output logic [1:0]  status
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  // index compare width: covers both the 6-bit index and the fill count
  localparam int XW = (CW > 6) ? CW : 6;

  mprqs_pkg::state_t state, state_next;

  logic [23:0] ready_mem [QUEUE_DEPTH];
  logic [23:0] blocked_mem [QUEUE_DEPTH];
  logic [23:0] rd_data;

  logic [1:0]  policy;
  logic [2:0]  act;
  logic [15:0] pid;
  logic [7:0]  pkey;
  logic [5:0]  bidx;
  logic [CW-1:0] ready_fill, blocked_fill;
  logic [15:0] run_id;
  logic [7:0]  run_key;
  logic        run_valid;
  logic [1:0]  st;
  logic [CW-1:0] ptr;
  logic [AW-1:0] best;
  logic [7:0]  best_key;

  logic ready_full, blocked_full, bad_idx, better;
  assign ready_full   = ready_fill >= CW'(QUEUE_DEPTH);
  assign blocked_full = blocked_fill >= CW'(QUEUE_DEPTH);
  assign bad_idx      = XW'(bidx) >= XW'(blocked_fill);
  // shared comparator
  assign better = (policy == mprqs_pkg::POL_SJF)  ? (rd_data[7:0] < best_key) :
                  (policy == mprqs_pkg::POL_PRIO) ? (rd_data[7:0] > best_key) : 1'b0;

  // single read port, address chosen by state
  logic [AW-1:0] rd_addr;
  logic          rd_blk;
  always_comb begin
    rd_blk  = 1'b0;
    rd_addr = ptr[AW-1:0];
    case (state)
      mprqs_pkg::S_TAKE:  rd_addr = best;
      mprqs_pkg::S_BREAD: begin rd_blk = 1'b1; rd_addr = AW'(bidx); end
      mprqs_pkg::S_BSHIFT: begin rd_blk = 1'b1; rd_addr = AW'(ptr + 1'b1); end
      mprqs_pkg::S_RSHIFT: rd_addr = AW'(ptr + 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= rd_blk ? blocked_mem[rd_addr] : ready_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      mprqs_pkg::S_IDLE:   if (start) state_next = mprqs_pkg::S_DECODE;
      mprqs_pkg::S_DECODE: begin
        state_next = mprqs_pkg::S_DONE;
        case (act)
          mprqs_pkg::ACT_UNBLOCK:
            if (!bad_idx && !ready_full) state_next = mprqs_pkg::S_BREAD;
          mprqs_pkg::ACT_KILL:
            if (!bad_idx) state_next = mprqs_pkg::S_BSHIFT;
          mprqs_pkg::ACT_DISPATCH:
            if (!run_valid && ready_fill != '0) state_next = mprqs_pkg::S_SCAN;
          default: ;
        endcase
      end
      mprqs_pkg::S_SCAN:      state_next = mprqs_pkg::S_SCAN_WAIT;
      mprqs_pkg::S_SCAN_WAIT:
        state_next = (ptr + 1'b1 >= ready_fill) ? mprqs_pkg::S_TAKE : mprqs_pkg::S_SCAN;
      mprqs_pkg::S_TAKE:      state_next = mprqs_pkg::S_TAKE_WAIT;
      mprqs_pkg::S_TAKE_WAIT: state_next = mprqs_pkg::S_RSHIFT;
      mprqs_pkg::S_RSHIFT:
        state_next = (ptr + 1'b1 >= ready_fill) ? mprqs_pkg::S_DONE : mprqs_pkg::S_RSHIFT_WR;
      mprqs_pkg::S_RSHIFT_WR: state_next = mprqs_pkg::S_RSHIFT;
      mprqs_pkg::S_BREAD:      state_next = mprqs_pkg::S_BREAD_WAIT;
      mprqs_pkg::S_BREAD_WAIT: state_next = mprqs_pkg::S_BSHIFT;
      mprqs_pkg::S_BSHIFT:
        state_next = (ptr + 1'b1 >= blocked_fill) ? mprqs_pkg::S_DONE : mprqs_pkg::S_BSHIFT_WR;
      mprqs_pkg::S_BSHIFT_WR: state_next = mprqs_pkg::S_BSHIFT;
      mprqs_pkg::S_DONE:      state_next = mprqs_pkg::S_IDLE;
      default:                state_next = mprqs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy      = state != mprqs_pkg::S_IDLE;
    cfg_ready = state == mprqs_pkg::S_IDLE;
    done      = state == mprqs_pkg::S_DONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mprqs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (state == mprqs_pkg::S_DECODE) begin
      if (act == mprqs_pkg::ACT_ADMIT && !ready_full)
        ready_mem[ready_fill[AW-1:0]] <= {pid, pkey};
      if (act == mprqs_pkg::ACT_EXPIRE && run_valid && policy == mprqs_pkg::POL_RR &&
          !ready_full)
        ready_mem[ready_fill[AW-1:0]] <= {run_id, run_key};
      if (act == mprqs_pkg::ACT_BLOCK && run_valid && !blocked_full)
        blocked_mem[blocked_fill[AW-1:0]] <= {run_id, run_key};
    end
    if (state == mprqs_pkg::S_BREAD_WAIT)
      ready_mem[ready_fill[AW-1:0]] <= rd_data;
    if (state == mprqs_pkg::S_RSHIFT_WR) ready_mem[ptr[AW-1:0]] <= rd_data;
    if (state == mprqs_pkg::S_BSHIFT_WR) blocked_mem[ptr[AW-1:0]] <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (state == mprqs_pkg::S_IDLE && start) begin
      act <= action; pid <= process_id; pkey <= sched_key; bidx <= blocked_index;
    end
    case (state)
      mprqs_pkg::S_DECODE: begin
        ptr <= (act == mprqs_pkg::ACT_DISPATCH) ? '0 : CW'(bidx);
        best <= '0;
      end
      mprqs_pkg::S_SCAN_WAIT: begin
        if (ptr == '0 || better) begin
          best <= ptr[AW-1:0];
          best_key <= rd_data[7:0];
        end
        ptr <= ptr + 1'b1;
      end
      mprqs_pkg::S_TAKE: ptr <= CW'(best);
      mprqs_pkg::S_RSHIFT_WR, mprqs_pkg::S_BSHIFT_WR: ptr <= ptr + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= mprqs_pkg::POL_FIFO;
      ready_fill <= '0; blocked_fill <= '0;
      run_valid <= 1'b0; run_id <= '0; run_key <= '0;
      st <= mprqs_pkg::ST_OK;
    end else begin
      if (cfg_valid && cfg_ready) policy <= cfg_data;
      case (state)
        mprqs_pkg::S_DECODE: begin
          st <= mprqs_pkg::ST_OK;
          case (act)
            mprqs_pkg::ACT_ADMIT:
              if (ready_full) st <= mprqs_pkg::ST_FULL;
              else ready_fill <= ready_fill + 1'b1;
            mprqs_pkg::ACT_BLOCK:
              if (!run_valid) st <= mprqs_pkg::ST_IDLE;
              else if (blocked_full) st <= mprqs_pkg::ST_FULL;
              else begin
                blocked_fill <= blocked_fill + 1'b1;
                run_valid <= 1'b0; run_id <= '0; run_key <= '0;
              end
            mprqs_pkg::ACT_FINISH:
              if (!run_valid) st <= mprqs_pkg::ST_IDLE;
              else begin run_valid <= 1'b0; run_id <= '0; run_key <= '0; end
            mprqs_pkg::ACT_EXPIRE:
              if (!run_valid) st <= mprqs_pkg::ST_IDLE;
              else if (policy == mprqs_pkg::POL_RR) begin
                if (ready_full) st <= mprqs_pkg::ST_FULL;
                else begin
                  ready_fill <= ready_fill + 1'b1;
                  run_valid <= 1'b0; run_id <= '0; run_key <= '0;
                end
              end else if (policy == mprqs_pkg::POL_SJF) begin
                run_valid <= 1'b0; run_id <= '0; run_key <= '0;
              end
            mprqs_pkg::ACT_UNBLOCK:
              if (bad_idx) st <= mprqs_pkg::ST_BAD_INDEX;
              else if (ready_full) st <= mprqs_pkg::ST_FULL;
            mprqs_pkg::ACT_KILL:
              if (bad_idx) st <= mprqs_pkg::ST_BAD_INDEX;
            mprqs_pkg::ACT_DISPATCH:
              if (!run_valid && ready_fill == '0) st <= mprqs_pkg::ST_IDLE;
            default: ;
          endcase
        end
        mprqs_pkg::S_TAKE_WAIT: begin
          run_valid <= 1'b1; run_id <= rd_data[23:8]; run_key <= rd_data[7:0];
        end
        mprqs_pkg::S_BREAD_WAIT: ready_fill <= ready_fill + 1'b1;
        mprqs_pkg::S_RSHIFT:
          if (ptr + 1'b1 >= ready_fill) ready_fill <= ready_fill - 1'b1;
        mprqs_pkg::S_BSHIFT:
          if (ptr + 1'b1 >= blocked_fill) blocked_fill <= blocked_fill - 1'b1;
        default: ;
      endcase
    end
  end

  assign running_valid = run_valid;
  assign running_id    = run_id;
  assign running_key   = run_key;
  assign ready_count   = 7'(ready_fill);
  assign blocked_count = 7'(blocked_fill);
  assign status        = st;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ready_fill <= CW'(QUEUE_DEPTH) && blocked_fill <= CW'(QUEUE_DEPTH))
    else $error("fill count above depth");
  a_idle_slot: assert property (@(posedge clk) disable iff (rst)
    !run_valid |-> (run_id == '0 && run_key == '0))
    else $error("empty slot holds data");
  a_done_after: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy after done");
  a_dispatch_runs: assert property (@(posedge clk) disable iff (rst)
    (state == mprqs_pkg::S_TAKE_WAIT) |=> run_valid)
    else $error("dispatch left slot empty");

endmodule
